@@ src/gdfw_pkg.sv @@
// ----------------------------------------------------------------------------
// gdfw_pkg
// Shared constants, codes and controller/datapath interface types for the
// depth-first graph walk block.
// ----------------------------------------------------------------------------
package gdfw_pkg;

   // Graph and stack sizing.
   localparam int MAX_NODES   = 64;
   localparam int STACK_DEPTH = 4096;

   // Node field width on the ports and row index width inside the block.
   localparam int NODE_W  = 6;
   localparam int RIDX_W  = $clog2(MAX_NODES);
   localparam int SP_W    = $clog2(STACK_DEPTH + 1);
   localparam int SADDR_W = $clog2(STACK_DEPTH);

   // Request action codes.
   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_ADD   = 2'd1;
   localparam logic [1:0] ACT_WALK  = 2'd2;

   // Response kinds.
   localparam logic KIND_ACK  = 1'b0;
   localparam logic KIND_NODE = 1'b1;

   // Adjacency row address select.
   localparam logic [1:0] RSEL_A   = 2'd0;
   localparam logic [1:0] RSEL_B   = 2'd1;
   localparam logic [1:0] RSEL_CUR = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;      // latch the request fields
      logic       clear_graph;  // drop every adjacency row
      logic       row_rd;       // read one adjacency row
      logic       row_wr;       // write back a row with one more edge bit
      logic [1:0] row_sel;      // which node addresses the row
      logic       walk_init;    // clear visited map, push the start node
      logic       pop;          // pop the stack top into the read register
      logic       visit;        // mark the popped node, report previous one
      logic       load_mask;    // form the unvisited neighbor mask
      logic       scan_step;    // test one mask bit and push it if set and the stack has room
      logic       emit_ack;     // send an acknowledgement response
      logic       emit_last;    // send the held node as the final response
   } gdfw_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] action;
      logic       edge_ok;
      logic       walk_ok;
      logic       stack_empty;
      logic       cur_visited;
      logic       pend_valid;
      logic       out_free;
      logic       scan_done;
   } gdfw_status_type;

endpackage

@@ src/gdfw_ctrl.sv @@
// ----------------------------------------------------------------------------
// gdfw_ctrl
// Controller state machine: sequences edge updates, graph clears and the
// stack-driven walk by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module gdfw_ctrl
   import gdfw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  gdfw_status_type status,
   output gdfw_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_WR_A     = 4'd2;
   localparam logic [3:0] S_RD_B     = 4'd3;
   localparam logic [3:0] S_WR_B     = 4'd4;
   localparam logic [3:0] S_ACK      = 4'd5;
   localparam logic [3:0] S_POP      = 4'd6;
   localparam logic [3:0] S_CHECK    = 4'd7;
   localparam logic [3:0] S_LOAD     = 4'd8;
   localparam logic [3:0] S_SCAN     = 4'd9;
   localparam logic [3:0] S_FLUSH    = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.action)
               ACT_CLEAR: begin
                  cmd.clear_graph = 1'b1;
                  state_in        = S_ACK;
               end
               ACT_ADD: begin
                  if (status.edge_ok) begin
                     cmd.row_rd  = 1'b1;
                     cmd.row_sel = RSEL_A;
                     state_in    = S_WR_A;
                  end else begin
                     state_in = S_ACK;
                  end
               end
               ACT_WALK: begin
                  if (status.walk_ok) begin
                     cmd.walk_init = 1'b1;
                     state_in      = S_POP;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_WR_A: begin
            cmd.row_wr  = 1'b1;
            cmd.row_sel = RSEL_A;
            state_in    = S_RD_B;
         end
         S_RD_B: begin
            cmd.row_rd  = 1'b1;
            cmd.row_sel = RSEL_B;
            state_in    = S_WR_B;
         end
         S_WR_B: begin
            cmd.row_wr  = 1'b1;
            cmd.row_sel = RSEL_B;
            state_in    = S_ACK;
         end
         S_ACK: begin
            if (status.out_free) begin
               cmd.emit_ack = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_POP: begin
            if (status.stack_empty) begin
               state_in = S_FLUSH;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // A visited node is dropped; a new one waits until the previous
            // report can move into the response register.
            if (status.cur_visited) begin
               state_in = S_POP;
            end else if (!status.pend_valid || status.out_free) begin
               cmd.visit   = 1'b1;
               cmd.row_rd  = 1'b1;
               cmd.row_sel = RSEL_CUR;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load_mask = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = S_POP;
            end
         end
         S_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/gdfw_dpath.sv @@
// ----------------------------------------------------------------------------
// gdfw_dpath
// Datapath: adjacency row memory with per-row valid bits, walk stack memory
// and pointer, visited map, neighbor scan mask, held node and the response
// register.
// ----------------------------------------------------------------------------
module gdfw_dpath
   import gdfw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_action,
   input  logic [NODE_W-1:0]   req_node_a,
   input  logic [NODE_W-1:0]   req_node_b,
   input  gdfw_cmd_type        cmd,
   output gdfw_status_type     status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_kind,
   output logic [NODE_W-1:0]   rsp_node_id,
   output logic                rsp_last
);

   // Memories.
   logic [MAX_NODES-1:0] adj_mem   [MAX_NODES];
   logic [NODE_W-1:0]    stack_mem [STACK_DEPTH];

   // Captured request.
   logic [1:0]        cap_action_ff;
   logic [NODE_W-1:0] cap_a_ff;
   logic [NODE_W-1:0] cap_b_ff;

   // Row read path.
   logic [MAX_NODES-1:0] row_q_ff;
   logic                 rowv_q_ff;
   logic [MAX_NODES-1:0] row_vld_ff;
   logic [MAX_NODES-1:0] row_vld_in;
   logic [RIDX_W-1:0]    row_addr;
   logic [RIDX_W-1:0]    edge_bit;
   logic [MAX_NODES-1:0] row_eff;
   logic [MAX_NODES-1:0] row_wdata;

   // Walk state.
   logic [MAX_NODES-1:0] visited_ff;
   logic [MAX_NODES-1:0] visited_in;
   logic [SP_W-1:0]      sp_ff;
   logic [SP_W-1:0]      sp_in;
   logic [SP_W-1:0]      sp_m1;
   logic                 stack_full;
   logic [NODE_W-1:0]    stk_q_ff;
   logic [RIDX_W-1:0]    cur_idx;
   logic                 stk_we;
   logic [SADDR_W-1:0]   stk_waddr;
   logic [NODE_W-1:0]    stk_wdata;
   logic                 push_now;
   logic [MAX_NODES-1:0] mask_ff;
   logic [MAX_NODES-1:0] mask_in;
   logic [RIDX_W-1:0]    scan_ff;
   logic [RIDX_W-1:0]    scan_in;
   logic                 pend_valid_ff;
   logic                 pend_valid_in;
   logic [NODE_W-1:0]    pend_node_ff;
   logic [NODE_W-1:0]    pend_node_in;

   // Response register.
   logic              out_valid_ff;
   logic              out_valid_in;
   logic              out_kind_ff;
   logic              out_kind_in;
   logic [NODE_W-1:0] out_node_ff;
   logic [NODE_W-1:0] out_node_in;
   logic              out_last_ff;
   logic              out_last_in;
   logic              out_free;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_action_ff <= req_action;
         cap_a_ff      <= req_node_a;
         cap_b_ff      <= req_node_b;
      end
   end

   // Row address and write data; a row that is not valid reads as empty.
   assign cur_idx = stk_q_ff[RIDX_W-1:0];
   always_comb begin
      case (cmd.row_sel)
         RSEL_A: begin
            row_addr = cap_a_ff[RIDX_W-1:0];
            edge_bit = cap_b_ff[RIDX_W-1:0];
         end
         RSEL_B: begin
            row_addr = cap_b_ff[RIDX_W-1:0];
            edge_bit = cap_a_ff[RIDX_W-1:0];
         end
         default: begin
            row_addr = cur_idx;
            edge_bit = cur_idx;
         end
      endcase
   end

   assign row_eff   = rowv_q_ff ? row_q_ff : '0;
   assign row_wdata = row_eff | (MAX_NODES'(1) << edge_bit);

   // Adjacency memory: one read or one write per cycle, registered read.
   always_ff @(posedge clock) begin
      if (cmd.row_wr) begin
         adj_mem[row_addr] <= row_wdata;
      end
      if (cmd.row_rd) begin
         row_q_ff  <= adj_mem[row_addr];
         rowv_q_ff <= row_vld_ff[row_addr];
      end
   end

   // Row valid bits: a clear drops every row at once.
   always_comb begin
      row_vld_in = row_vld_ff;
      if (cmd.clear_graph) begin
         row_vld_in = '0;
      end else if (cmd.row_wr) begin
         row_vld_in[row_addr] = 1'b1;
      end
   end

   // Stack pointer and push/pop.
   assign sp_m1      = sp_ff - SP_W'(1);
   assign stack_full = (sp_ff == SP_W'(STACK_DEPTH));
   assign push_now   = cmd.scan_step && mask_ff[scan_ff] && !stack_full;

   always_comb begin
      sp_in = sp_ff;
      if (cmd.walk_init) begin
         sp_in = SP_W'(1);
      end else if (cmd.pop) begin
         sp_in = sp_m1;
      end else if (push_now) begin
         sp_in = sp_ff + SP_W'(1);
      end
   end

   always_comb begin
      stk_we    = 1'b0;
      stk_waddr = sp_ff[SADDR_W-1:0];
      stk_wdata = NODE_W'(scan_ff);
      if (cmd.walk_init) begin
         stk_we    = 1'b1;
         stk_waddr = '0;
         stk_wdata = cap_a_ff;
      end else if (push_now) begin
         stk_we = 1'b1;
      end
   end

   // Stack memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (cmd.pop) begin
         stk_q_ff <= stack_mem[sp_m1[SADDR_W-1:0]];
      end
   end

   // Visited map, neighbor mask and scan index.
   always_comb begin
      visited_in = visited_ff;
      if (cmd.walk_init) begin
         visited_in = '0;
      end else if (cmd.visit) begin
         visited_in[cur_idx] = 1'b1;
      end
   end

   always_comb begin
      mask_in = mask_ff;
      scan_in = scan_ff;
      if (cmd.load_mask) begin
         mask_in = row_eff & ~visited_ff;
         scan_in = '0;
      end else if (cmd.scan_step) begin
         scan_in = scan_ff + RIDX_W'(1);
      end
   end

   // Held node: the latest visit is reported only once its successor or
   // the end of the walk is known, so the final one can carry last.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_node_in  = pend_node_ff;
      if (cmd.walk_init || cmd.emit_last) begin
         pend_valid_in = 1'b0;
      end else if (cmd.visit) begin
         pend_valid_in = 1'b1;
         pend_node_in  = stk_q_ff;
      end
   end

   // Response register loads.
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_node_in  = out_node_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit_ack) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_ACK;
         out_node_in  = '0;
         out_last_in  = 1'b1;
      end else if (cmd.visit && pend_valid_ff) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_NODE;
         out_node_in  = pend_node_ff;
         out_last_in  = 1'b0;
      end else if (cmd.emit_last) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_NODE;
         out_node_in  = pend_node_ff;
         out_last_in  = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff    <= '0;
         visited_ff    <= '0;
         sp_ff         <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         row_vld_ff    <= row_vld_in;
         visited_ff    <= visited_in;
         sp_ff         <= sp_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mask_ff      <= mask_in;
      scan_ff      <= scan_in;
      pend_node_ff <= pend_node_in;
      out_kind_ff  <= out_kind_in;
      out_node_ff  <= out_node_in;
      out_last_ff  <= out_last_in;
   end

   // Status to the controller.
   always_comb begin
      status.action      = cap_action_ff;
      status.edge_ok     = ({1'b0, cap_a_ff} < (NODE_W + 1)'(MAX_NODES)) &&
                           ({1'b0, cap_b_ff} < (NODE_W + 1)'(MAX_NODES));
      status.walk_ok     = ({1'b0, cap_a_ff} < (NODE_W + 1)'(MAX_NODES));
      status.stack_empty = (sp_ff == '0);
      status.cur_visited = visited_ff[cur_idx];
      status.pend_valid  = pend_valid_ff;
      status.out_free    = out_free;
      status.scan_done   = (scan_ff == RIDX_W'(MAX_NODES - 1));
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_kind    = out_kind_ff;
   assign rsp_node_id = out_node_ff;
   assign rsp_last    = out_last_ff;

endmodule

@@ src/graph_depth_first_walk.sv @@
// ----------------------------------------------------------------------------
// graph_depth_first_walk
// Depth-first walk over an undirected graph held as an adjacency bit matrix.
//
// Usage: a request (req_action, req_node_a, req_node_b) clears the graph,
// adds an undirected edge, or walks the graph from req_node_a. Responses
// leave on rsp_kind, rsp_node_id and rsp_last; rsp_last marks the final
// response of each request. Clear and edge add give one acknowledgement;
// a walk gives one report per reached node, highest neighbor first.
// Both channels use valid/ready; one request is in progress at a time.
// An edge add reads and rewrites both adjacency rows through the single
// memory port. A walk scans the 64-bit neighbor row of each reached node
// bit-serially and drops stale stack entries as it pops them; the final
// report leaves after the stack drains.
// The response register decouples the sides: a new request is taken while
// a response waits. When the receiver stalls, the walk stops at the next
// report until the register frees up. Reset empties the graph, the stack
// and the response register; no clearing pass is needed afterward.
// ----------------------------------------------------------------------------
module graph_depth_first_walk
   import gdfw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic [NODE_W-1:0] req_node_a,
   input  logic [NODE_W-1:0] req_node_b,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [NODE_W-1:0] rsp_node_id,
   output logic              rsp_last
);

   gdfw_cmd_type    cmd;
   gdfw_status_type status;

   gdfw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gdfw_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_action  (req_action),
      .req_node_a  (req_node_a),
      .req_node_b  (req_node_b),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_kind    (rsp_kind),
      .rsp_node_id (rsp_node_id),
      .rsp_last    (rsp_last)
   );

   // Responses are only loaded when the response register can take them.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_ack || cmd.emit_last || (cmd.visit && status.pend_valid))
      |-> status.out_free)
      else $error("response loaded while the response register is busy");

   // The controller never pops an empty stack.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !status.stack_empty)
      else $error("pop issued on an empty stack");

   // One request at a time: ready drops right after a request is taken.
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request accepted while one is in progress");

   // A walk leaves nothing held once the block is ready again.
   a_no_stale_pend: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !status.pend_valid)
      else $error("held node left over at the end of a walk");

endmodule
